// ===== sv/pohvc_pkg.sv =====
// ----------------------------------------------------------------------------
// pohvc_pkg
// Shared types, constants and tables of the pose-hold velocity controller:
// CORDIC step count, arctangent table, sequencer states, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pohvc_pkg;

  // CORDIC iterations, capped at ATAN_LEN (24); the arctangent table defines 17 entries
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // angles in Q4.16 radians
  localparam int ANG_W = 20;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 20'sd102944;

  // configuration register indexes
  localparam logic [1:0] CFG_MOVE_GAIN = 2'd0;
  localparam logic [1:0] CFG_ROT_GAIN  = 2'd1;
  localparam logic [1:0] CFG_HOLD_EN   = 2'd2;
  localparam logic [1:0] CFG_MIN_OFF   = 2'd3;

  // sequencer states
  typedef enum logic [11:0] {
    ST_IDLE = 12'b0000_0000_0001,
    ST_OFF  = 12'b0000_0000_0010,
    ST_SQ   = 12'b0000_0000_0100,
    ST_DB   = 12'b0000_0000_1000,
    ST_MAT  = 12'b0000_0001_0000,
    ST_CLP  = 12'b0000_0010_0000,
    ST_SQS  = 12'b0000_0100_0000,
    ST_ISQ  = 12'b0000_1000_0000,
    ST_PRE  = 12'b0001_0000_0000,
    ST_ROT  = 12'b0010_0000_0000,
    ST_GAIN = 12'b0100_0000_0000,
    ST_DONE = 12'b1000_0000_0000
  } state_t;

  // atan(2^-i) in Q4.16, rounded to nearest
  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
    logic signed [ANG_W-1:0] v;
    v = '0;
    unique case (i)
      5'd0:    v = 20'sd51472;
      5'd1:    v = 20'sd30386;
      5'd2:    v = 20'sd16055;
      5'd3:    v = 20'sd8150;
      5'd4:    v = 20'sd4091;
      5'd5:    v = 20'sd2047;
      5'd6:    v = 20'sd1024;
      5'd7:    v = 20'sd512;
      5'd8:    v = 20'sd256;
      5'd9:    v = 20'sd128;
      5'd10:   v = 20'sd64;
      5'd11:   v = 20'sd32;
      5'd12:   v = 20'sd16;
      5'd13:   v = 20'sd8;
      5'd14:   v = 20'sd4;
      5'd15:   v = 20'sd2;
      5'd16:   v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // product matrix entries needed: R00, R10, R20, R21, R22 (row, column)
  function automatic logic [1:0] mat_row(input logic [2:0] e);
    logic [1:0] r;
    r = 2'd0;
    unique case (e)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mat_col(input logic [2:0] e);
    logic [1:0] c;
    c = 2'd0;
    unique case (e)
      3'd3:    c = 2'd1;
      3'd4:    c = 2'd2;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pose_hold_velocity_controller.sv =====
// One item at a time: in_ready is high only while idle, and the shared
//   multiplier, the square-root step and the CORDIC rotation loop are
//   sequenced over each item. Save requests and ignored samples never leave
//   the idle state; an offset axis at one metre or more skips the dead-band
//   test. Synchronous active-low reset clears sequencer, checkpoint flags,
//   result valid and loads the default register values.
// ----------------------------------------------------------------------------
// pose_hold_velocity_controller
// Proportional pose hold: offset of the current pose from a saved checkpoint
// drives linear commands, ZYX Euler angles of the relative rotation drive
// angular commands. One multiplier, one isqrt step unit and one CORDIC stage
// are sequenced over many cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_hold_velocity_controller (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_action,
  input  wire logic signed [31:0]  in_translation_x,
  input  wire logic signed [31:0]  in_translation_y,
  input  wire logic signed [31:0]  in_translation_z,
  input  wire logic [47:0]         in_rotation_row0,
  input  wire logic [47:0]         in_rotation_row1,
  input  wire logic [47:0]         in_rotation_row2,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       out_linear_x,
  output logic signed [31:0]       out_linear_y,
  output logic signed [31:0]       out_linear_z,
  output logic signed [31:0]       out_angular_x,
  output logic signed [31:0]       out_angular_y,
  output logic signed [31:0]       out_angular_z
);
  import pohvc_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_N - 1);

  // control state
  state_t state_r, state_nxt;
  logic   save_pending_r, cp_valid_r, out_valid_r;
  logic signed [15:0] move_gain_r, rot_gain_r;
  logic               hold_en_r;
  logic [15:0]        min_off_r;

  // datapath state
  logic signed [31:0] tr_r  [3];
  logic signed [15:0] cur_r [3][3];
  logic signed [31:0] cpt_r [3];
  logic signed [15:0] cpr_r [3][3];
  logic signed [32:0] off_r [3];
  logic signed [35:0] acc_r;
  logic signed [32:0] rm_r  [5];
  logic [4:0]         cnt_r;
  logic [2:0]         ent_r;
  logic [1:0]         job_r;
  logic signed [29:0] s_r;
  logic [57:0]        rad_r, root_r, bit_r;
  logic signed [35:0] cx_r, cy_r;
  logic signed [ANG_W-1:0] cz_r;
  logic signed [ANG_W-1:0] ang_r [3];
  logic signed [31:0] res_r [6];
  logic signed [31:0] out_r [6];

  logic in_fire, tr_zero, go_run, big;
  logic signed [32:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [62:0] mul_p, mul_sh;
  logic signed [35:0] acc_sum;
  logic signed [31:0] sat_val;
  logic signed [33:0] neg_s;
  logic signed [35:0] pre_x, pre_y, xs, ys;
  logic signed [ANG_W-1:0] z_step;
  logic [57:0]        root_try;
  logic               db_small;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign tr_zero  = (in_translation_x == '0) && (in_translation_y == '0) &&
                    (in_translation_z == '0);
  assign go_run   = (cp_valid_r || save_pending_r) && hold_en_r;

  // any axis at one metre or more skips the dead-band test
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if ((off_r[i] >= 33'sd65536) || (off_r[i] <= -33'sd65536)) big = 1'b1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQ: begin
        mul_a = off_r[cnt_r[1:0]];
        mul_b = {{13{off_r[cnt_r[1:0]][16]}}, off_r[cnt_r[1:0]][16:0]};
      end
      ST_DB: begin
        mul_a = {17'b0, min_off_r};
        mul_b = {14'b0, min_off_r};
      end
      ST_MAT: begin
        mul_a = {{17{cur_r[mat_row(ent_r)][cnt_r[1:0]][15]}},
                 cur_r[mat_row(ent_r)][cnt_r[1:0]]};
        mul_b = {{14{cpr_r[mat_col(ent_r)][cnt_r[1:0]][15]}},
                 cpr_r[mat_col(ent_r)][cnt_r[1:0]]};
      end
      ST_SQS: begin
        mul_a = {{3{s_r[29]}}, s_r};
        mul_b = s_r;
      end
      ST_GAIN: begin
        mul_b = {{14{move_gain_r[15]}}, move_gain_r};
        unique case (cnt_r[2:0])
          3'd0: mul_a = off_r[1];
          3'd1: mul_a = off_r[0];
          3'd2: mul_a = -off_r[2];
          3'd3: mul_a = -{{13{ang_r[2][ANG_W-1]}}, ang_r[2]};
          3'd4: mul_a = -{{13{ang_r[0][ANG_W-1]}}, ang_r[0]};
          default: mul_a = -{{13{ang_r[1][ANG_W-1]}}, ang_r[1]};
        endcase
        if (cnt_r[2:0] >= 3'd3) mul_b = {{14{rot_gain_r[15]}}, rot_gain_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign acc_sum  = acc_r + mul_p[35:0];
  assign db_small = ({{27{acc_r[35]}}, acc_r} < mul_p);

  // floor shift by 8 and saturate to 32 bits
  assign mul_sh  = mul_p >>> 8;
  always_comb begin
    if ((mul_sh[62:31] == '0) || (mul_sh[62:31] == '1)) sat_val = mul_sh[31:0];
    else if (mul_sh[62]) sat_val = 32'sh8000_0000;
    else sat_val = 32'sh7fff_ffff;
  end

  assign neg_s    = -{rm_r[2][32], rm_r[2]};
  assign root_try = root_r + bit_r;

  // CORDIC operand pick for the current angle
  always_comb begin
    unique case (job_r)
      2'd0: begin
        pre_y = {{6{s_r[29]}}, s_r};
        pre_x = {7'b0, root_r[28:0]};
      end
      2'd1: begin
        pre_y = {{3{rm_r[1][32]}}, rm_r[1]};
        pre_x = {{3{rm_r[0][32]}}, rm_r[0]};
      end
      default: begin
        pre_y = {{3{rm_r[3][32]}}, rm_r[3]};
        pre_x = {{3{rm_r[4][32]}}, rm_r[4]};
      end
    endcase
  end

  assign xs     = cx_r >>> cnt_r;
  assign ys     = cy_r >>> cnt_r;
  assign z_step = atan_entry(cnt_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire && !in_action && !tr_zero && go_run) state_nxt = ST_OFF;
      ST_OFF:  state_nxt = ST_SQ;
      ST_SQ: begin
        if (big) state_nxt = ST_MAT;
        else if (cnt_r == 5'd2) state_nxt = ST_DB;
      end
      ST_DB:   state_nxt = db_small ? ST_IDLE : ST_MAT;
      ST_MAT:  if ((ent_r == 3'd4) && (cnt_r == 5'd2)) state_nxt = ST_CLP;
      ST_CLP:  state_nxt = ST_SQS;
      ST_SQS:  state_nxt = ST_ISQ;
      ST_ISQ:  if (bit_r[0]) state_nxt = ST_PRE;
      ST_PRE: begin
        if ((pre_x == '0) && (pre_y == '0)) state_nxt = (job_r == 2'd2) ? ST_GAIN : ST_PRE;
        else state_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (cnt_r == LAST_STEP) state_nxt = (job_r == 2'd2) ? ST_GAIN : ST_PRE;
      end
      ST_GAIN: if (cnt_r == 5'd5) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      save_pending_r <= 1'b0;
      cp_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      move_gain_r    <= 16'sd1280;
      rot_gain_r     <= 16'sd64;
      hold_en_r      <= 1'b0;
      min_off_r      <= 16'd131;
    end else begin
      state_r <= state_nxt;
      // take config writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MOVE_GAIN: move_gain_r <= cfg_data;
          CFG_ROT_GAIN:  rot_gain_r  <= cfg_data;
          CFG_HOLD_EN:   hold_en_r   <= cfg_data[0];
          CFG_MIN_OFF:   min_off_r   <= cfg_data;
          default: ;
        endcase
      end
      // save request arms; next nonzero pose becomes the checkpoint
      if (in_fire) begin
        if (in_action) save_pending_r <= 1'b1;
        else if (!tr_zero && save_pending_r) begin
          save_pending_r <= 1'b0;
          cp_valid_r     <= 1'b1;
        end
      end
      // hand off result
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      else if ((state_r == ST_DONE) && !out_valid_r) out_valid_r <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_action && !tr_zero) begin
          tr_r[0] <= in_translation_x;
          tr_r[1] <= in_translation_y;
          tr_r[2] <= in_translation_z;
          for (int j = 0; j < 3; j++) begin
            cur_r[0][j] <= in_rotation_row0[16*j +: 16];
            cur_r[1][j] <= in_rotation_row1[16*j +: 16];
            cur_r[2][j] <= in_rotation_row2[16*j +: 16];
          end
          if (save_pending_r) begin
            cpt_r[0] <= in_translation_x;
            cpt_r[1] <= in_translation_y;
            cpt_r[2] <= in_translation_z;
            for (int j = 0; j < 3; j++) begin
              cpr_r[0][j] <= in_rotation_row0[16*j +: 16];
              cpr_r[1][j] <= in_rotation_row1[16*j +: 16];
              cpr_r[2][j] <= in_rotation_row2[16*j +: 16];
            end
          end
        end
      end
      ST_OFF: begin
        for (int i = 0; i < 3; i++) begin
          off_r[i] <= {tr_r[i][31], tr_r[i]} - {cpt_r[i][31], cpt_r[i]};
        end
        acc_r <= '0;
        cnt_r <= '0;
      end
      ST_SQ: begin
        acc_r <= big ? 36'sd0 : acc_sum;
        cnt_r <= big ? 5'd0 : cnt_r + 5'd1;
        ent_r <= '0;
      end
      ST_DB: begin
        acc_r <= '0;
        cnt_r <= '0;
        ent_r <= '0;
      end
      ST_MAT: begin
        // accumulate one dot product, store at the third term
        if (cnt_r == 5'd2) begin
          rm_r[ent_r] <= acc_sum[32:0];
          acc_r       <= '0;
          cnt_r       <= '0;
          ent_r       <= ent_r + 3'd1;
        end else begin
          acc_r <= acc_sum;
          cnt_r <= cnt_r + 5'd1;
        end
      end
      ST_CLP: begin
        // clamp asin argument to [-1, 1]
        if (neg_s > 34'sd268435456) s_r <= 30'sd268435456;
        else if (neg_s < -34'sd268435456) s_r <= -30'sd268435456;
        else s_r <= neg_s[29:0];
      end
      ST_SQS: begin
        rad_r  <= (58'd1 << 56) - mul_p[57:0];
        root_r <= '0;
        bit_r  <= 58'd1 << 56;
      end
      ST_ISQ: begin
        // one digit of the integer square root
        if (rad_r >= root_try) begin
          rad_r  <= rad_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        job_r <= '0;
      end
      ST_PRE: begin
        cnt_r <= '0;
        if ((pre_x == '0) && (pre_y == '0)) begin
          ang_r[job_r] <= '0;
          job_r        <= job_r + 2'd1;
        end else if (pre_x < 0) begin
          if (pre_y >= 0) begin
            cx_r <= pre_y;
            cy_r <= -pre_x;
            cz_r <= ANG_HALF_PI;
          end else begin
            cx_r <= -pre_y;
            cy_r <= pre_x;
            cz_r <= -ANG_HALF_PI;
          end
        end else begin
          cx_r <= pre_x;
          cy_r <= pre_y;
          cz_r <= '0;
        end
      end
      ST_ROT: begin
        // one vectoring rotation toward the x axis
        if (cy_r >= 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + z_step;
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - z_step;
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          ang_r[job_r] <= (cy_r >= 0) ? cz_r + z_step : cz_r - z_step;
          job_r        <= job_r + 2'd1;
          cnt_r        <= '0;
        end
      end
      ST_GAIN: begin
        res_r[cnt_r[2:0]] <= sat_val;
        cnt_r             <= cnt_r + 5'd1;
      end
      ST_DONE: begin
        if (!out_valid_r) begin
          for (int i = 0; i < 6; i++) out_r[i] <= res_r[i];
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_linear_x  = out_r[0];
  assign out_linear_y  = out_r[1];
  assign out_linear_z  = out_r[2];
  assign out_angular_x = out_r[3];
  assign out_angular_y = out_r[4];
  assign out_angular_z = out_r[5];

endmodule

`default_nettype wire

// ===== sv/pohvc_checker.sv =====
// ----------------------------------------------------------------------------
// pohvc_checker
// Port-level checks of the pose-hold velocity controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module pohvc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_action,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_linear_x,
  input wire logic [31:0] out_angular_z
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_linear_x) && $stable(out_angular_z))
    else $error("result changed while stalled");

  // drop out of reset with no result
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a save request never produces a result
  a_save_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action && !out_valid |=> !out_valid)
    else $error("result after save request");

  // a new result is only presented while busy
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

endmodule

bind pose_hold_velocity_controller pohvc_checker u_pohvc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_action     (in_action),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_linear_x  (out_linear_x),
  .out_angular_z (out_angular_z)
);

`default_nettype wire
